FILE: sv/shl_pkg.sv
package shl_pkg;

  // lane and block geometry
  localparam int LANE_W      = 96;
  localparam int UPPER_W     = 64;
  localparam int LOWER_W     = 32;
  localparam int BLOCK_BYTES = 6;
  localparam int BLOCK_W     = 48;
  localparam int RC_LEN      = 104;
  localparam int RC_IDX_W    = 7;
  localparam int QUEUE_DEPTH = 2;

  // domain separation byte placed after the message
  localparam logic [7:0] PAD_BYTE = 8'h04;

  // rotation amounts of one round
  localparam int ROT_A5 = 55;
  localparam int ROT_A4 = 8;
  localparam int ROT_A1 = 1;

  // what the back end has to do with one block
  typedef enum logic [1:0] {
    CMD_ABSORB,
    CMD_FINAL,
    CMD_FINAL_PAD
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [BLOCK_W-1:0]   word;
  } cmd_t;

  typedef struct packed {
    logic running;
    logic emitting;
  } core_status_t;

  localparam logic [7:0] RC_TABLE [RC_LEN] = '{
    8'h04, 8'h07, 8'h01, 8'h0D, 8'h15, 8'h25, 8'h44, 8'h06,
    8'h03, 8'h09, 8'h1D, 8'h35, 8'h64, 8'h47, 8'h00, 8'h0F,
    8'h11, 8'h2D, 8'h54, 8'h26, 8'h42, 8'h0A, 8'h1B, 8'h39,
    8'h7C, 8'h77, 8'h61, 8'h4D, 8'h14, 8'h27, 8'h40, 8'h0E,
    8'h13, 8'h29, 8'h5C, 8'h36, 8'h62, 8'h4B, 8'h18, 8'h3F,
    8'h70, 8'h6F, 8'h51, 8'h2C, 8'h56, 8'h22, 8'h4A, 8'h1A,
    8'h3B, 8'h78, 8'h7F, 8'h71, 8'h6D, 8'h55, 8'h24, 8'h46,
    8'h02, 8'h0B, 8'h19, 8'h3D, 8'h74, 8'h67, 8'h41, 8'h0C,
    8'h17, 8'h21, 8'h4C, 8'h16, 8'h23, 8'h48, 8'h1E, 8'h33,
    8'h68, 8'h5F, 8'h30, 8'h6E, 8'h53, 8'h28, 8'h5E, 8'h32,
    8'h6A, 8'h5B, 8'h38, 8'h7E, 8'h73, 8'h69, 8'h5D, 8'h34,
    8'h66, 8'h43, 8'h08, 8'h1F, 8'h31, 8'h6C, 8'h57, 8'h20,
    8'h4E, 8'h12, 8'h2B, 8'h58, 8'h3E, 8'h72, 8'h6B, 8'h59
  };

  // round constant lookup
  function automatic logic [7:0] rc_byte(input logic [RC_IDX_W-1:0] idx);
    logic [7:0] r;
    r = 8'h00;
    if (int'(idx) < RC_LEN) begin
      r = RC_TABLE[idx];
    end
    return r;
  endfunction

  // rotate a 96-bit lane left by a fixed amount
  function automatic logic [LANE_W-1:0] rotl96(input logic [LANE_W-1:0] x, input int r);
    logic [2*LANE_W-1:0] d;
    d = {x, x} << r;
    return d[2*LANE_W-1:LANE_W];
  endfunction

endpackage

FILE: sv/shl_front.sv
module shl_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [47:0]               block_data,
  input  logic [2:0]                byte_count,
  input  logic                      final_block,
  input  logic                      block_valid,
  output logic                      block_stall,
  output logic                      cmd_valid,
  output shl_pkg::cmd_t             cmd,
  input  logic                      cmd_stall
);

  logic [2:0]     n_sat;
  shl_pkg::cmd_t  cmd_next;

  // saturate count, build padded block and pick the command
  always_comb begin
    n_sat = (byte_count > 3'(shl_pkg::BLOCK_BYTES)) ? 3'(shl_pkg::BLOCK_BYTES) : byte_count;
    cmd_next.word = block_data;
    if (!final_block) begin
      cmd_next.kind = shl_pkg::CMD_ABSORB;
    end else if (n_sat == 3'(shl_pkg::BLOCK_BYTES)) begin
      cmd_next.kind = shl_pkg::CMD_FINAL_PAD;
    end else begin
      cmd_next.kind = shl_pkg::CMD_FINAL;
      for (int b = 0; b < shl_pkg::BLOCK_BYTES; b++) begin
        if (3'(b) < n_sat) begin
          cmd_next.word[8*b +: 8] = block_data[8*b +: 8];
        end else if (3'(b) == n_sat) begin
          cmd_next.word[8*b +: 8] = shl_pkg::PAD_BYTE;
        end else begin
          cmd_next.word[8*b +: 8] = 8'h00;
        end
      end
    end
  end

  assign block_stall = cmd_valid && cmd_stall;

  // entry register
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!block_stall) begin
      cmd_valid <= block_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!block_stall && block_valid) begin
      cmd <= cmd_next;
    end
  end

endmodule

FILE: sv/shl_queue.sv
module shl_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  input  shl_pkg::cmd_t  wr_cmd,
  output logic           wr_stall,
  output logic           rd_valid,
  output shl_pkg::cmd_t  rd_cmd,
  input  logic           rd_stall
);

  localparam int PW = $clog2(shl_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(shl_pkg::QUEUE_DEPTH + 1);

  shl_pkg::cmd_t  slots [shl_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           push;
  logic           pop;

  assign wr_stall = (count == CW'(shl_pkg::QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_cmd   = slots[rd_ptr];
  assign push     = wr_valid && !wr_stall;
  assign pop      = rd_valid && !rd_stall;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

endmodule

FILE: sv/shl_core.sv
module shl_core #(
  parameter int ROUNDS = 104
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  input  shl_pkg::cmd_t          cmd,
  output logic                   cmd_stall,
  output logic [63:0]            lane_upper,
  output logic [31:0]            lane_lower,
  output logic                   last_word,
  output logic                   lane_valid,
  input  logic                   lane_stall,
  output shl_pkg::core_status_t  status
);

  localparam int RW = ($clog2(ROUNDS) > 0) ? $clog2(ROUNDS) : 1;
  localparam int LW = shl_pkg::LANE_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_EMIT0,
    ST_EMIT1
  } state_t;

  state_t           state;
  logic [RW-1:0]    rnd;
  logic             pad_pending;
  logic             squeeze;
  logic             second;
  logic [LW-1:0]    a0, a1, a2, a4, a5;
  logic [LW-1:0]    a0x, t1, t2, a4b, a4c;
  logic [LW-1:0]    a0_next, a1_next, a2_next, a4_next, a5_next;
  logic             out_free;
  logic             last_round;
  logic             beat_load;

  assign cmd_stall       = (state != ST_IDLE);
  assign out_free        = !lane_valid || !lane_stall;
  assign last_round      = (rnd == RW'(ROUNDS - 1));
  assign beat_load       = ((state == ST_EMIT0) || (state == ST_EMIT1)) && out_free;
  assign status.running  = (state == ST_RUN);
  assign status.emitting = (state == ST_EMIT0) || (state == ST_EMIT1);

  // one round of the permutation
  always_comb begin
    a0x = a0;
    a0x[LW-1:shl_pkg::LOWER_W] = a0[LW-1:shl_pkg::LOWER_W]
      ^ shl_pkg::UPPER_W'(shl_pkg::rc_byte(shl_pkg::RC_IDX_W'(rnd)));
    t1      = ~a5 ^ a0x;
    a2_next = (a1 | a4) ^ t1;
    a4b     = a4 ^ (a1 & ~a0x);
    a0_next = (t1 & a4b) ^ a1 ^ a5;
    t2      = (a2_next & (a1 ^ a5)) ^ a4b;
    a4c     = a4b ^ a5;
    a5_next = shl_pkg::rotl96(a4c, shl_pkg::ROT_A5);
    a4_next = shl_pkg::rotl96(a2_next, shl_pkg::ROT_A4);
    a1_next = shl_pkg::rotl96(t2, shl_pkg::ROT_A1);
  end

  // sequencer, lanes and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      rnd         <= '0;
      pad_pending <= 1'b0;
      squeeze     <= 1'b0;
      second      <= 1'b0;
      lane_valid  <= 1'b0;
      a0 <= '0; a1 <= '0; a2 <= '0; a4 <= '0; a5 <= '0;
    end else begin
      if (lane_valid && !lane_stall && !beat_load) begin
        lane_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            a0[LW-1:shl_pkg::LOWER_W] <= a0[LW-1:shl_pkg::LOWER_W]
              ^ shl_pkg::UPPER_W'(cmd.word);
            pad_pending <= (cmd.kind == shl_pkg::CMD_FINAL_PAD);
            squeeze     <= (cmd.kind != shl_pkg::CMD_ABSORB);
            second      <= 1'b0;
            rnd         <= '0;
            state       <= ST_RUN;
          end
        end
        ST_RUN: begin
          a1 <= a1_next; a2 <= a2_next; a4 <= a4_next; a5 <= a5_next;
          if (last_round && pad_pending) begin
            // full last block: absorb the separate pad block right away
            a0 <= {a0_next[LW-1:shl_pkg::LOWER_W] ^ shl_pkg::UPPER_W'(shl_pkg::PAD_BYTE),
                   a0_next[shl_pkg::LOWER_W-1:0]};
          end else begin
            a0 <= a0_next;
          end
          if (last_round) begin
            rnd <= '0;
            if (pad_pending) begin
              pad_pending <= 1'b0;
            end else if (squeeze) begin
              state <= ST_EMIT0;
            end else begin
              state <= ST_IDLE;
            end
          end else begin
            rnd <= rnd + 1'b1;
          end
        end
        ST_EMIT0: begin
          if (out_free) begin
            lane_upper <= a0[LW-1:shl_pkg::LOWER_W];
            lane_lower <= a0[shl_pkg::LOWER_W-1:0];
            last_word  <= 1'b0;
            lane_valid <= 1'b1;
            state      <= ST_EMIT1;
          end
        end
        ST_EMIT1: begin
          if (out_free) begin
            lane_upper <= a1[LW-1:shl_pkg::LOWER_W];
            lane_lower <= a1[shl_pkg::LOWER_W-1:0];
            last_word  <= second;
            lane_valid <= 1'b1;
            if (second) begin
              // digest done: lanes back to zero for the next message
              a0 <= '0; a1 <= '0; a2 <= '0; a4 <= '0; a5 <= '0;
              state <= ST_IDLE;
            end else begin
              second <= 1'b1;
              state  <= ST_RUN;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sv/sponge_hash_96bit_lanes_unit.sv
// Sponge hash over five 96-bit lanes. Each accepted beat carries one 48-bit
// block; a front register pads and classifies it and a two-entry queue hands
// it to the permutation engine, which runs one round per clock. An ordinary
// block is loaded into the engine and then permuted for ROUNDS rounds; the
// engine takes no new block until it is idle again. A final block adds the
// squeeze: two result beats, a second permutation of ROUNDS rounds, two more
// beats (the last one flagged by last_word); a final block of six bytes adds
// a further permutation of ROUNDS rounds for the pad block. After the fourth
// beat the lanes are zero again and the next message can start.
module sponge_hash_96bit_lanes_unit #(
  parameter int ROUNDS = 104
) (
  input  logic         clk,
  input  logic         rst,
  input  logic [47:0]  block_data,
  input  logic [2:0]   byte_count,
  input  logic         final_block,
  input  logic         block_valid,
  output logic         block_stall,
  output logic [63:0]  lane_upper,
  output logic [31:0]  lane_lower,
  output logic         last_word,
  output logic         lane_valid,
  input  logic         lane_stall
);

  logic                   fq_valid;
  shl_pkg::cmd_t          fq_cmd;
  logic                   fq_stall;
  logic                   qc_valid;
  shl_pkg::cmd_t          qc_cmd;
  logic                   qc_stall;
  shl_pkg::core_status_t  core_st;

  // pad and classify
  shl_front u_front (
    .clk         (clk),
    .rst         (rst),
    .block_data  (block_data),
    .byte_count  (byte_count),
    .final_block (final_block),
    .block_valid (block_valid),
    .block_stall (block_stall),
    .cmd_valid   (fq_valid),
    .cmd         (fq_cmd),
    .cmd_stall   (fq_stall)
  );

  // decoupling queue
  shl_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_cmd   (fq_cmd),
    .wr_stall (fq_stall),
    .rd_valid (qc_valid),
    .rd_cmd   (qc_cmd),
    .rd_stall (qc_stall)
  );

  // permutation engine and squeeze
  shl_core #(
    .ROUNDS (ROUNDS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (qc_valid),
    .cmd        (qc_cmd),
    .cmd_stall  (qc_stall),
    .lane_upper (lane_upper),
    .lane_lower (lane_lower),
    .last_word  (last_word),
    .lane_valid (lane_valid),
    .lane_stall (lane_stall),
    .status     (core_st)
  );

  // a result only appears out of a squeeze step
  assert property (@(posedge clk) disable iff (rst)
    $rose(lane_valid) |-> $past(core_st.emitting))
    else $error("result beat without squeeze");

  // the final beat of a digest is never followed directly by another beat
  assert property (@(posedge clk) disable iff (rst)
    (lane_valid && !lane_stall && last_word) |=> !lane_valid)
    else $error("beat right after final digest word");

  // no block leaves the queue while the engine is permuting
  assert property (@(posedge clk) disable iff (rst)
    core_st.running |-> qc_stall)
    else $error("queue popped during permutation");

endmodule
